// ===== rtl/hllcs_pkg.sv =====
// hllcs_pkg: shared types and constants of the hyperloglog cardinality sketch
// no dependencies; used by the front, queue, back and top level rtl files and the bench
`timescale 1ns / 1ps

package hllcs_pkg;

    localparam int HASH_W   = 32;
    localparam int IDX_W    = 16;   // widest register index the block supports
    localparam int RANK_W   = 5;
    localparam int P_W      = 5;    // clamped precision, 4..15
    localparam int CFG_W    = 4;
    localparam int T_W      = 34;   // sum of 2^(cap-reg), at most 2^33
    localparam int NUM_W    = 48;
    localparam int DEN_W    = 32;
    localparam int DVD_W    = 128;
    localparam int DVS_W    = 64;
    localparam int Q_W      = 74;   // raw estimate in q40 stays below 2^74
    localparam int E_W      = 80;   // corrected estimate in q40
    localparam int X_W      = 72;   // log argument
    localparam int L_W      = 64;
    localparam int FRAC_W   = 50;
    localparam int LOG_STEPS = 50;
    localparam int Q_FRAC   = 40;

    localparam logic [CFG_W-1:0] PRECISION_RESET = 4'd10;
    localparam logic [P_W-1:0]   P_MIN           = 5'd4;
    localparam logic [P_W-1:0]   P_BIG           = 5'd7;

    localparam logic [13:0] ALPHA_BIG = 14'd7213;
    localparam logic [13:0] ALPHA_16  = 14'd673;
    localparam logic [13:0] ALPHA_32  = 14'd697;
    localparam logic [13:0] ALPHA_64  = 14'd709;
    localparam logic [DEN_W-1:0] DEN_SCALE = 32'd10000;
    localparam logic [DEN_W-1:0] DEN_OFFS  = 32'd10790;
    localparam logic [DEN_W-1:0] DEN_SMALL = 32'd1000;
    localparam logic [L_W-1:0]   LN2_Q64   = 64'hB17217F7D1CF79AB;
    localparam logic [6:0]       LARGE_BASE = 7'd72;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_ESTIMATE = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
    } item_t;

    typedef struct packed {
        logic  full;
        logic  empty;
    } queue_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_INS,
        ST_CLR,
        ST_SUM,
        ST_SUM_LAST,
        ST_DEN,
        ST_DIV,
        ST_RANGE,
        ST_NORM,
        ST_SQ,
        ST_SQ_DONE,
        ST_LN,
        ST_LN_DONE,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/hllcs_ram.sv =====
// hllcs_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps

module hllcs_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/hllcs_fifo.sv =====
// hllcs_fifo: two-entry queue of classified transactions between front and back
// depends on hllcs_pkg
`timescale 1ns / 1ps

module hllcs_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  hllcs_pkg::item_t         push_item,
    input  logic                     pop,
    output hllcs_pkg::item_t         head,
    output hllcs_pkg::queue_status_t status
);

    hllcs_pkg::item_t entry_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign head         = entry_reg[rptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// ===== rtl/hllcs_front.sv =====
// hllcs_front: takes input transactions, drops unused opcodes and works out
// register index and rank of inserts; depends on hllcs_pkg
`timescale 1ns / 1ps

module hllcs_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [hllcs_pkg::HASH_W-1:0]  s_hash_value,
    input  logic [hllcs_pkg::P_W-1:0]     p_eff,
    input  logic                          accept_en,
    input  hllcs_pkg::queue_status_t      q_status,
    output logic                          push,
    output hllcs_pkg::item_t              item
);

    logic [5:0]                       restw;
    logic [5:0]                       cap;
    logic [hllcs_pkg::HASH_W-1:0]     rest;
    logic [hllcs_pkg::HASH_W-1:0]     shifted;
    logic [4:0]                       tz;
    logic                             op_ok;

    always_comb begin
        restw   = 6'd32 - {1'b0, p_eff};
        cap     = 6'd33 - {1'b0, p_eff};
        rest    = s_hash_value & 32'((33'd1 << restw) - 33'd1);
        shifted = s_hash_value >> restw;
        // lowest set bit of the bits below the index
        tz = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (rest[i]) begin
                tz = 5'(i);
            end
        end
        item.idx  = shifted[hllcs_pkg::IDX_W-1:0];
        item.rank = (rest == '0) ? cap[4:0] : tz + 5'd1;
        case (s_opcode)
            hllcs_pkg::OP_INSERT: begin
                item.op = hllcs_pkg::OP_INSERT;
                op_ok   = 1'b1;
            end
            hllcs_pkg::OP_CLEAR: begin
                item.op = hllcs_pkg::OP_CLEAR;
                op_ok   = 1'b1;
            end
            hllcs_pkg::OP_ESTIMATE: begin
                item.op = hllcs_pkg::OP_ESTIMATE;
                op_ok   = 1'b1;
            end
            default: begin
                item.op = hllcs_pkg::OP_INSERT;
                op_ok   = 1'b0;
            end
        endcase
        s_ready = accept_en & ~q_status.full;
        push    = s_valid & s_ready & op_ok;
    end

endmodule

// ===== rtl/hllcs_back.sv =====
// hllcs_back: executes queued transactions against the rank memory: update,
// clear sweep, estimate sweep, divider, log unit and output register
// depends on hllcs_pkg and hllcs_ram
`timescale 1ns / 1ps

module hllcs_back #(
    parameter int MAX_LOG2 = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hllcs_pkg::P_W-1:0]     p_eff,
    input  hllcs_pkg::queue_status_t      q_status,
    input  hllcs_pkg::item_t              q_head,
    output logic                          q_pop,
    output logic                          accept_en,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_estimate,
    output logic                          m_saturated
);

    localparam int DEPTH = 1 << MAX_LOG2;
    localparam int CW    = MAX_LOG2;
    localparam int VW    = MAX_LOG2 + 1;

    hllcs_pkg::state_t               state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    hllcs_pkg::item_t                item_reg, item_next;
    logic [hllcs_pkg::T_W-1:0]       t_reg, t_next;
    logic [VW-1:0]                   v_reg, v_next;
    logic [hllcs_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [hllcs_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [hllcs_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [hllcs_pkg::Q_W-1:0]       quo_reg, quo_next;
    logic [6:0]                      dcnt_reg, dcnt_next;
    logic [hllcs_pkg::E_W-1:0]       e_reg, e_next;
    logic                            force_reg, force_next;
    logic                            small_reg, small_next;
    logic [6:0]                      base_reg, base_next;
    logic [hllcs_pkg::X_W-1:0]       x_reg, x_next;
    logic [6:0]                      k_reg, k_next;
    logic [63:0]                     res_reg, res_next;
    logic [5:0]                      it_reg, it_next;
    logic [63:0]                     mul_a_reg, mul_a_next;
    logic [63:0]                     mul_b_reg, mul_b_next;
    logic [127:0]                    acc_reg, acc_next;
    logic [1:0]                      mcnt_reg, mcnt_next;
    logic                            mv_reg, mv_next;
    logic [31:0]                     est_reg, est_next;
    logic                            sat_reg, sat_next;

    logic                            ram_we;
    logic [CW-1:0]                   ram_waddr;
    logic [hllcs_pkg::RANK_W-1:0]    ram_wdata;
    logic [CW-1:0]                   ram_raddr;
    logic [hllcs_pkg::RANK_W-1:0]    ram_rdata;

    // combinational helpers
    logic [5:0]                      cap;
    logic [hllcs_pkg::RANK_W-1:0]    rd_cl;
    logic [hllcs_pkg::T_W-1:0]       t_inc;
    logic [CW-1:0]                   m_last;
    logic [31:0]                     a_half, b_half;
    logic [63:0]                     pp;
    logic [6:0]                      mshift;
    logic [127:0]                    acc_step;
    logic [63:0]                     sq, ln;
    logic [64:0]                     trial;
    logic                            ge;
    logic [hllcs_pkg::Q_W-1:0]       small_lim;
    logic [76:0]                     e30;
    logic                            e_large;
    logic [hllcs_pkg::NUM_W-1:0]     num;
    logic [hllcs_pkg::DEN_W-1:0]     den;
    logic [65:0]                     dprod;
    logic [63:0]                     res_new, mant_new, l_val;
    logic [80:0]                     rnd;
    logic                            rnd_sat;

    hllcs_ram #(
        .WIDTH (hllcs_pkg::RANK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hllcs_pkg::ST_INIT;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            force_reg <= 1'b0;
            mcnt_reg  <= 2'd0;
            dcnt_reg  <= 7'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
            force_reg <= force_next;
            mcnt_reg  <= mcnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
        dvd_reg   <= dvd_next;
        dvs_reg   <= dvs_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        e_reg     <= e_next;
        small_reg <= small_next;
        base_reg  <= base_next;
        x_reg     <= x_next;
        k_reg     <= k_next;
        res_reg   <= res_next;
        it_reg    <= it_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        est_reg   <= est_next;
        sat_reg   <= sat_next;
    end

    always_comb begin
        cap    = 6'd33 - {1'b0, p_eff};
        rd_cl  = ({1'b0, ram_rdata} > cap) ? cap[4:0] : ram_rdata;
        t_inc  = hllcs_pkg::T_W'(1) << (cap - {1'b0, rd_cl});
        m_last = CW'((VW'(1) << p_eff) - VW'(1));

        // one 32x32 partial product per cycle into the accumulator
        a_half   = mcnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        b_half   = mcnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pp       = a_half * b_half;
        mshift   = {2'(mcnt_reg[1]) + 2'(mcnt_reg[0]), 5'b0};
        acc_step = acc_reg + (128'(pp) << mshift);
        sq       = acc_reg[125:62];
        ln       = acc_reg[127:64];

        trial = {rem_reg, dvd_reg[hllcs_pkg::DVD_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});

        small_lim = hllcs_pkg::Q_W'(5) << ({2'b0, p_eff} + 7'd39);
        e30   = 77'({quo_reg[63:0], 5'b0}) - 77'({quo_reg[63:0], 1'b0});
        e_large = (e30 > (77'(1) << 72)) || (quo_reg[73:64] != '0);

        if (p_eff >= hllcs_pkg::P_BIG) begin
            num = hllcs_pkg::NUM_W'(hllcs_pkg::ALPHA_BIG) << {p_eff, 1'b0};
            den = (hllcs_pkg::DEN_SCALE << p_eff) + hllcs_pkg::DEN_OFFS;
        end else if (p_eff == hllcs_pkg::P_MIN) begin
            num = hllcs_pkg::NUM_W'(hllcs_pkg::ALPHA_16) << p_eff;
            den = hllcs_pkg::DEN_SMALL;
        end else if (p_eff == hllcs_pkg::P_MIN + 5'd1) begin
            num = hllcs_pkg::NUM_W'(hllcs_pkg::ALPHA_32) << p_eff;
            den = hllcs_pkg::DEN_SMALL;
        end else begin
            num = hllcs_pkg::NUM_W'(hllcs_pkg::ALPHA_64) << p_eff;
            den = hllcs_pkg::DEN_SMALL;
        end
        dprod = 66'(den) * 66'(t_reg);

        if (sq[63]) begin
            res_new  = res_reg | (64'(1) << (it_reg - 6'd1));
            mant_new = {1'b0, sq[63:1]};
        end else begin
            res_new  = res_reg;
            mant_new = sq;
        end
        l_val = (64'(base_reg) << hllcs_pkg::FRAC_W) - res_new;

        rnd     = {1'b0, e_reg} + (81'(1) << (hllcs_pkg::Q_FRAC - 1));
        rnd_sat = force_reg || (rnd[80:72] != '0);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        item_next  = item_reg;
        t_next     = t_reg;
        v_next     = v_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        e_next     = e_reg;
        force_next = force_reg;
        small_next = small_reg;
        base_next  = base_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        it_next    = it_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        acc_next   = acc_reg;
        mcnt_next  = mcnt_reg;
        mv_next    = mv_reg & ~m_ready;
        est_next   = est_reg;
        sat_next   = sat_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg;
        ram_wdata  = '0;
        ram_raddr  = cnt_reg;

        case (state_reg)
            hllcs_pkg::ST_INIT, hllcs_pkg::ST_CLR: begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == '1) begin
                    state_next = hllcs_pkg::ST_IDLE;
                end
            end
            hllcs_pkg::ST_IDLE: begin
                ram_raddr = q_head.idx[CW-1:0];
                if (!q_status.empty) begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    cnt_next  = '0;
                    case (q_head.op)
                        hllcs_pkg::OP_INSERT:   state_next = hllcs_pkg::ST_INS;
                        hllcs_pkg::OP_CLEAR:    state_next = hllcs_pkg::ST_CLR;
                        hllcs_pkg::OP_ESTIMATE: begin
                            t_next     = '0;
                            v_next     = '0;
                            pend_next  = 1'b0;
                            state_next = hllcs_pkg::ST_SUM;
                        end
                        default: state_next = hllcs_pkg::ST_IDLE;
                    endcase
                end
            end
            hllcs_pkg::ST_INS: begin
                ram_waddr = item_reg.idx[CW-1:0];
                ram_wdata = item_reg.rank;
                ram_we    = (ram_rdata < item_reg.rank);
                state_next = hllcs_pkg::ST_IDLE;
            end
            hllcs_pkg::ST_SUM, hllcs_pkg::ST_SUM_LAST: begin
                // read data is registered and belongs to the address of the previous cycle
                if (pend_reg) begin
                    t_next = t_reg + t_inc;
                    v_next = v_reg + VW'(ram_rdata == '0);
                end
                if (state_reg == hllcs_pkg::ST_SUM_LAST) begin
                    pend_next  = 1'b0;
                    state_next = hllcs_pkg::ST_DEN;
                end else begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                    if (cnt_reg == m_last) begin
                        state_next = hllcs_pkg::ST_SUM_LAST;
                    end
                end
            end
            hllcs_pkg::ST_DEN: begin
                dvd_next   = hllcs_pkg::DVD_W'(num) << 73;
                dvs_next   = dprod[63:0];
                rem_next   = '0;
                quo_next   = '0;
                dcnt_next  = 7'd0;
                state_next = hllcs_pkg::ST_DIV;
            end
            hllcs_pkg::ST_DIV: begin
                rem_next  = ge ? 64'(trial - {1'b0, dvs_reg}) : trial[63:0];
                quo_next  = {quo_reg[hllcs_pkg::Q_W-2:0], ge};
                dvd_next  = {dvd_reg[hllcs_pkg::DVD_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + 7'd1;
                if (dcnt_reg == 7'd127) begin
                    state_next = hllcs_pkg::ST_RANGE;
                end
            end
            hllcs_pkg::ST_RANGE: begin
                e_next     = hllcs_pkg::E_W'(quo_reg);
                force_next = 1'b0;
                k_next     = 7'(hllcs_pkg::X_W - 1);
                state_next = hllcs_pkg::ST_OUT;
                if (quo_reg <= small_lim) begin
                    // linear counting while empty registers remain
                    if (v_reg != '0) begin
                        x_next     = hllcs_pkg::X_W'(v_reg);
                        base_next  = 7'(p_eff);
                        small_next = 1'b1;
                        state_next = hllcs_pkg::ST_NORM;
                    end
                end else if (e_large) begin
                    if (quo_reg[73:72] != 2'b00) begin
                        force_next = 1'b1;
                    end else begin
                        x_next     = 72'((73'(1) << 72) - 73'(quo_reg));
                        base_next  = hllcs_pkg::LARGE_BASE;
                        small_next = 1'b0;
                        state_next = hllcs_pkg::ST_NORM;
                    end
                end
            end
            hllcs_pkg::ST_NORM: begin
                if (x_reg[hllcs_pkg::X_W-1]) begin
                    mul_a_next = {1'b0, x_reg[71:9]};
                    mul_b_next = {1'b0, x_reg[71:9]};
                    res_next   = 64'(k_reg) << hllcs_pkg::FRAC_W;
                    it_next    = 6'(hllcs_pkg::LOG_STEPS);
                    acc_next   = '0;
                    mcnt_next  = 2'd0;
                    state_next = hllcs_pkg::ST_SQ;
                end else begin
                    x_next = {x_reg[hllcs_pkg::X_W-2:0], 1'b0};
                    k_next = k_reg - 7'd1;
                end
            end
            hllcs_pkg::ST_SQ, hllcs_pkg::ST_LN: begin
                acc_next  = acc_step;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3) begin
                    state_next = (state_reg == hllcs_pkg::ST_SQ) ?
                                 hllcs_pkg::ST_SQ_DONE : hllcs_pkg::ST_LN_DONE;
                end
            end
            hllcs_pkg::ST_SQ_DONE: begin
                res_next  = res_new;
                it_next   = it_reg - 6'd1;
                acc_next  = '0;
                mcnt_next = 2'd0;
                if (it_reg == 6'd1) begin
                    mul_a_next = l_val;
                    mul_b_next = hllcs_pkg::LN2_Q64;
                    state_next = hllcs_pkg::ST_LN;
                end else begin
                    mul_a_next = mant_new;
                    mul_b_next = mant_new;
                    state_next = hllcs_pkg::ST_SQ;
                end
            end
            hllcs_pkg::ST_LN_DONE: begin
                if (small_reg) begin
                    e_next = (hllcs_pkg::E_W'(ln) << p_eff) >> 10;
                end else begin
                    e_next = {ln[57:0], 22'b0};
                end
                state_next = hllcs_pkg::ST_OUT;
            end
            hllcs_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    sat_next   = rnd_sat;
                    est_next   = rnd_sat ? '1 : rnd[71:40];
                    state_next = hllcs_pkg::ST_IDLE;
                end
            end
            default: state_next = hllcs_pkg::ST_IDLE;
        endcase
    end

    assign accept_en   = (state_reg != hllcs_pkg::ST_INIT);
    assign m_valid     = mv_reg;
    assign m_estimate  = est_reg;
    assign m_saturated = sat_reg;

endmodule

// ===== rtl/hyperloglog_cardinality_sketch.sv =====
// hyperloglog_cardinality_sketch: top level, precision register and wiring of
// front, queue and back; depends on hllcs_pkg, hllcs_front, hllcs_fifo, hllcs_back
`timescale 1ns / 1ps
//
// Distinct-count sketch over 32-bit hashes.
// Input channel (s_valid/s_ready): s_opcode 0 inserts s_hash_value, 1 clears
// all rank registers, 2 requests an estimate; opcode 3 is taken and dropped.
// Result channel (m_valid/m_ready): one transaction per estimate request,
// m_estimate rounded and saturated at all ones, m_saturated set on overflow.
// cfg_wr_en/cfg_wr_data write the precision p (clamped to 4..MAX_REGISTERS_LOG2)
// and must only be written while the block is idle.
// Inserts: the execution side handles an insert as a memory read, then a
// conditional write; a two-entry queue sits in front of it.
// Clear: sweeps all 2^MAX_REGISTERS_LOG2 memory entries, one per cycle.
// Estimate: a memory sweep over the 2^p registers, bit-serial division, then
// for a range correction a normalize step, 50 squarings on the shared 32x32
// multiplier and a final product for the ln scaling.
// Reset: the memory is zeroed by a pass over all 2^MAX_REGISTERS_LOG2 entries
// during which s_ready stays low; precision resets to 10.
// A stalled result waits in the output register; inserts keep flowing until
// the next estimate reaches the output.
//

module hyperloglog_cardinality_sketch #(
    parameter int MAX_REGISTERS_LOG2 = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [31:0]                  s_hash_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [31:0]                  m_estimate,
    output logic                         m_saturated,
    input  logic                         cfg_wr_en,
    input  logic [hllcs_pkg::CFG_W-1:0]  cfg_wr_data
);

    logic [hllcs_pkg::CFG_W-1:0] precision_reg;
    logic [hllcs_pkg::P_W-1:0]   p_eff;
    logic                        push;
    logic                        q_pop;
    logic                        accept_en;
    hllcs_pkg::item_t            push_item;
    hllcs_pkg::item_t            q_head;
    hllcs_pkg::queue_status_t    q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            precision_reg <= hllcs_pkg::PRECISION_RESET;
        end else if (cfg_wr_en) begin
            precision_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if ({1'b0, precision_reg} < hllcs_pkg::P_MIN) begin
            p_eff = hllcs_pkg::P_MIN;
        end else if ({1'b0, precision_reg} > hllcs_pkg::P_W'(MAX_REGISTERS_LOG2)) begin
            p_eff = hllcs_pkg::P_W'(MAX_REGISTERS_LOG2);
        end else begin
            p_eff = {1'b0, precision_reg};
        end
    end

    hllcs_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_hash_value (s_hash_value),
        .p_eff        (p_eff),
        .accept_en    (accept_en),
        .q_status     (q_status),
        .push         (push),
        .item         (push_item)
    );

    hllcs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    hllcs_back #(
        .MAX_LOG2 (MAX_REGISTERS_LOG2)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .p_eff       (p_eff),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .accept_en   (accept_en),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_estimate  (m_estimate),
        .m_saturated (m_saturated)
    );

endmodule

// ===== rtl/hllcs_checker.sv =====
// hllcs_checker: port-level assertions for the sketch top level, with bind
// depends on hyperloglog_cardinality_sketch ports only
`timescale 1ns / 1ps

module hllcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_estimate,
    input logic        m_saturated
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_estimate) && $stable(m_saturated))
        else $error("result changed while stalled");

    // saturation flag always comes with an all-ones estimate
    a_sat_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_estimate == 32'hFFFFFFFF)
        else $error("saturated result without all-ones estimate");

    // memory clearing pass blocks input right after reset, no stale result
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active right after reset");

endmodule

bind hyperloglog_cardinality_sketch hllcs_checker u_hllcs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_estimate  (m_estimate),
    .m_saturated (m_saturated)
);

// ===== tb/hyperloglog_cardinality_sketch_test.sv =====
// hyperloglog_cardinality_sketch_test: self-checking bench for the hll sketch
// depends on hllcs_pkg and hyperloglog_cardinality_sketch; fixed-point predictor inside
`timescale 1ns / 1ps

module hyperloglog_cardinality_sketch_test;

    localparam int                REG_LOG2   = 12;
    localparam int                REG_COUNT  = 1 << REG_LOG2;
    localparam logic [1:0]        OP_UNUSED  = 2'd3;
    localparam logic [127:0]      LIMIT_Q40  = 128'd1 << 72;
    localparam int                DRAIN_GAP  = 13000;  // three queued clears plus slack

    typedef struct {
        logic [1:0]  op;
        logic [31:0] hash;
    } sketch_op_t;

    typedef struct {
        logic [31:0] est;
        logic        sat;
    } estimate_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = hllcs_pkg::OP_INSERT;
    logic [31:0] s_hash_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_estimate;
    logic        m_saturated;
    logic        cfg_wr_en = 1'b0;
    logic [hllcs_pkg::CFG_W-1:0] cfg_wr_data = '0;

    sketch_op_t  op_queue[$];
    estimate_t   expected_estimates[$];
    logic [4:0]  model_ranks[REG_COUNT];
    logic [3:0]  model_precision;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        offer_taken = 1'b0;
    logic        long_hold_arm = 1'b0;
    logic        long_hold_done = 1'b0;
    int          hold_left = 0;
    int          error_count = 0;
    int          n_inserts = 0;
    int          n_estimates = 0;
    int          n_saturated = 0;

    hyperloglog_cardinality_sketch #(.MAX_REGISTERS_LOG2(REG_LOG2)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_hash_value(s_hash_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_estimate(m_estimate), .m_saturated(m_saturated),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    function automatic int eff_precision();
        int p;
        p = model_precision;
        if (p < 4) p = 4;
        if (p > REG_LOG2) p = REG_LOG2;
        return p;
    endfunction

    // log2 in q50: msb index plus fifty bits by repeated squaring
    function automatic logic [63:0] log2_q50(input logic [127:0] x);
        int k;
        logic [63:0] mant, res;
        logic [127:0] sq;
        if (x == 0) return 64'd0;
        k = 0;
        for (int i = 0; i < 128; i++) if (x[i]) k = i;
        if (k >= 62) mant = 64'(x >> (k - 62));
        else mant = 64'(x << (62 - k));
        res = 64'(k) << 50;
        for (int i = 50; i > 0; i--) begin
            sq = {64'd0, mant} * {64'd0, mant};
            mant = 64'(sq >> 62);
            if (mant[63]) begin
                mant = mant >> 1;
                res[i-1] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] ln_q50(input logic [63:0] l2);
        logic [127:0] prod;
        prod = {64'd0, l2} * {64'd0, hllcs_pkg::LN2_Q64};
        return prod[127:64];
    endfunction

    function automatic estimate_t predict_estimate();
        int p, cap;
        logic [63:0] m, v, num, den, l;
        logic [127:0] t, e, r;
        int rk;
        estimate_t res;
        p = eff_precision();
        cap = 33 - p;
        m = 64'd1 << p;
        t = '0;
        v = '0;
        for (int i = 0; i < int'(m); i++) begin
            rk = model_ranks[i];
            if (rk == 0) v++;
            if (rk > cap) rk = cap;
            t += 128'd1 << (cap - rk);
        end
        if (m >= 128) begin
            num = 7213 * m * m;
            den = 10000 * m + 10790;
        end else if (m == 16) begin
            num = 673 * m;
            den = 1000;
        end else if (m == 32) begin
            num = 697 * m;
            den = 1000;
        end else begin
            num = 709 * m;
            den = 1000;
        end
        e = ({64'd0, num} << 73) / ({64'd0, den} * t);
        if (e <= ({64'd0, 5 * m} << 39)) begin
            // linear counting while some registers are still empty
            if (v != 0) begin
                l = (64'(p) << 50) - log2_q50({64'd0, v});
                e = ({64'd0, ln_q50(l)} * {64'd0, m}) >> 10;
            end
        end else if (({64'd0, e[63:0]} * 128'd30) > LIMIT_Q40 || e[127:64] != 0) begin
            if (e >= LIMIT_Q40) begin
                res.est = 32'hFFFF_FFFF;
                res.sat = 1'b1;
                return res;
            end
            l = (64'd72 << 50) - log2_q50(LIMIT_Q40 - e);
            e = {64'd0, ln_q50(l)} << 22;
        end
        r = (e + (128'd1 << 39)) >> 40;
        if (r > 128'hFFFF_FFFF) begin
            res.est = 32'hFFFF_FFFF;
            res.sat = 1'b1;
        end else begin
            res.est = r[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    task automatic apply_transaction(input logic [1:0] op, input logic [31:0] hash);
        int p, cap, rank, idx;
        logic [31:0] rest;
        p = eff_precision();
        cap = 33 - p;
        case (op)
            hllcs_pkg::OP_INSERT: begin
                idx = int'((hash >> (32 - p)) & (REG_COUNT - 1));
                rest = hash & ((32'd1 << (32 - p)) - 1);
                rank = 1;
                while (rank < cap && rest[0] == 1'b0) begin
                    rest = rest >> 1;
                    rank++;
                end
                if (model_ranks[idx] < rank) model_ranks[idx] = 5'(rank);
                n_inserts++;
            end
            hllcs_pkg::OP_CLEAR: begin
                foreach (model_ranks[i]) model_ranks[i] = '0;
            end
            hllcs_pkg::OP_ESTIMATE: begin
                expected_estimates.push_back(predict_estimate());
                n_estimates++;
            end
            default: ;
        endcase
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !offer_taken) begin
            s_valid <= 1'b1;
        end else if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s_opcode <= op_queue[0].op;
            s_hash_value <= op_queue[0].hash;
            void'(op_queue.pop_front());
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off counted here
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (long_hold_arm && !long_hold_done) begin
            hold_left <= 3000;
            long_hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: prediction on input transactions, checking on result transactions
    always @(posedge aclk) begin
        estimate_t exp_r;
        offer_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) apply_transaction(s_opcode, s_hash_value);
        if (aresetn && m_valid && m_ready) begin
            if (expected_estimates.size() == 0) begin
                $error("unexpected result: estimate=%0d saturated=%0d",
                       m_estimate, m_saturated);
                error_count++;
            end else begin
                exp_r = expected_estimates.pop_front();
                if (m_estimate !== exp_r.est) begin
                    $error("estimate: expected %0d, got %0d", exp_r.est, m_estimate);
                    error_count++;
                end
                if (m_saturated !== exp_r.sat) begin
                    $error("saturated: expected %0d, got %0d", exp_r.sat, m_saturated);
                    error_count++;
                end
                if (m_saturated === 1'b1) n_saturated++;
            end
        end
    end

    task automatic push_op(input logic [1:0] op, input logic [31:0] hash);
        sketch_op_t it;
        it.op = op;
        it.hash = hash;
        op_queue.push_back(it);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (op_queue.size() != 0 || (s_valid && !offer_taken)
                   || expected_estimates.size() != 0);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_precision(input logic [3:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        model_precision = value;
    endtask

    // random hash with a random run of trailing zeros, sometimes all zero below
    function automatic logic [31:0] random_hash();
        logic [31:0] h;
        int z;
        h = $urandom;
        if ($urandom_range(1)) begin
            z = $urandom_range(32);
            h = (z == 32) ? (h & 32'hF000_0000) : ((h >> z) << z);
        end
        return h;
    endfunction

    task automatic random_ops(input int count, input int est_pct);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < est_pct) push_op(hllcs_pkg::OP_ESTIMATE, $urandom);
            else if (roll < est_pct + 3) push_op(hllcs_pkg::OP_CLEAR, $urandom);
            else if (roll < est_pct + 5) push_op(OP_UNUSED, $urandom);
            else push_op(hllcs_pkg::OP_INSERT, random_hash());
        end
    endtask

    initial begin
        int prec_list[10];
        int send_list[4];
        int recv_list[4];
        prec_list = '{4, 12, 7, 15, 0, 5, 6, 10, 8, 13};
        send_list = '{0, 88, 0, 26};
        recv_list = '{0, 0, 88, 26};
        model_precision = hllcs_pkg::PRECISION_RESET;
        foreach (model_ranks[i]) model_ranks[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty sketch, hash extremes, unused opcode, both range ends
        push_op(hllcs_pkg::OP_ESTIMATE, 32'h0);
        push_op(hllcs_pkg::OP_INSERT, 32'h0);
        push_op(hllcs_pkg::OP_INSERT, 32'hFFFF_FFFF);
        push_op(hllcs_pkg::OP_INSERT, 32'h8000_0000);
        push_op(hllcs_pkg::OP_INSERT, 32'h0000_0001);
        push_op(OP_UNUSED, 32'hFFFF_FFFF);
        push_op(hllcs_pkg::OP_ESTIMATE, 32'hFFFF_FFFF);
        wait_drained();
        write_precision(4'd4);
        push_op(hllcs_pkg::OP_CLEAR, 32'h0);
        for (int i = 0; i < 16; i++) begin
            push_op(hllcs_pkg::OP_INSERT, (32'(i) << 28) | 32'h0200_0000);
        end
        push_op(hllcs_pkg::OP_ESTIMATE, 32'h0);
        push_op(hllcs_pkg::OP_INSERT, 32'h0);
        push_op(hllcs_pkg::OP_ESTIMATE, 32'h0);
        for (int i = 0; i < 16; i++) push_op(hllcs_pkg::OP_INSERT, 32'(i) << 28);
        push_op(hllcs_pkg::OP_ESTIMATE, 32'h0);
        wait_drained();
        // rank stored above the cap of a finer precision
        write_precision(4'd12);
        push_op(hllcs_pkg::OP_ESTIMATE, 32'h0);

        for (int ph = 0; ph < 10; ph++) begin
            wait_drained();
            write_precision(4'(prec_list[ph]));
            send_idle_pct = send_list[ph % 4];
            recv_stall_pct = recv_list[ph % 4];
            if (ph % 3 == 0) push_op(hllcs_pkg::OP_CLEAR, $urandom);
            random_ops(32, 10);
        end

        // back-pressure: receiver holds off while estimates pile up
        wait_drained();
        write_precision(4'd4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_ops(30, 40);
        long_hold_arm = 1'b1;
        wait_drained();

        $display("covered %0d inserts and %0d estimates (%0d saturated), precision 4 to 12",
                 n_inserts, n_estimates, n_saturated);
        $display("idle mixes: none, sender 88%%, receiver 88%%, both 26%%, plus one long stall");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
